FILE: rtl/e2cal_pkg.sv
// e2cal_pkg: constants, divisor values and helper functions for the epoch to
// UTC calendar pipeline. No dependencies.
`default_nettype none

package e2cal_pkg;

	localparam int unsigned DAY_STAGES = 9;
	localparam int unsigned ERA_STAGES = 6;
	localparam int unsigned SUB_STAGES = 3;
	localparam int unsigned PIPE_DEPTH = 26;

	// the three biases keep every dividend non-negative; SEC_BIAS is a whole number of days
	localparam logic [65:0] ERA_BIAS = 66'd1073741824;
	localparam logic [65:0] DAY_BIAS = 66'd719468 + 66'd146097 * ERA_BIAS;
	localparam logic [65:0] SEC_BIAS = 66'd86400 * DAY_BIAS;
	localparam logic [2:0]  WD_ADJ   = 3'((66'd11 - DAY_BIAS % 66'd7) % 66'd7);

	localparam logic [17:0] SECS_PER_DAY   = 18'd86400;
	localparam logic [17:0] SECS_PER_HOUR  = 18'd3600;
	localparam logic [17:0] SECS_PER_MIN   = 18'd60;
	localparam logic [17:0] DAYS_PER_ERA   = 18'd146097;
	localparam logic [17:0] DAYS_PER_WEEK  = 18'd7;
	localparam logic [17:0] DAYS_PER_4Y    = 18'd1460;
	localparam logic [17:0] DAYS_PER_100Y  = 18'd36524;
	localparam logic [17:0] DAYS_PER_YEAR  = 18'd365;
	localparam logic [17:0] LAST_ERA_DAY   = 18'd146096;
	localparam logic [47:0] BASE_YEAR      = 48'd1900;

	// eight restoring division steps; returns {remainder, quotient byte}
	function automatic logic [25:0] div_step(input logic [17:0] rem, input logic [7:0] din,
			input logic [17:0] dv);
		logic [18:0] r;
		logic [7:0]  q;
		r = {1'b0, rem};
		q = '0;
		for (int i = 7; i >= 0; i--) begin
			r = {r[17:0], din[i]};
			if (r >= {1'b0, dv}) begin
				r    = r - {1'b0, dv};
				q[i] = 1'b1;
			end
		end
		return {r[17:0], q};
	endfunction

	// first day of each month in a year that starts on 1 March
	function automatic logic [8:0] mar_start(input logic [3:0] m);
		logic [8:0] d;
		case (m)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd61;
			4'd3:    d = 9'd92;
			4'd4:    d = 9'd122;
			4'd5:    d = 9'd153;
			4'd6:    d = 9'd184;
			4'd7:    d = 9'd214;
			4'd8:    d = 9'd245;
			4'd9:    d = 9'd275;
			4'd10:   d = 9'd306;
			4'd11:   d = 9'd337;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/epoch_seconds_to_utc_calendar_top.sv
// done marks the result of each word that start handed in; one word per cycle while busy is low.
// busy is high only in the first cycle after reset, then stays low: a word enters every cycle.
// Byte-wide long division stages set the depth (9 for seconds to days, 6 for the era split).
// arst_n clears the valid chain and sets busy; payload registers are not reset.
// Uses e2cal_pkg. Splits signed epoch seconds into the UTC calendar fields.
// The year comes from the 400-year era, years within the era and a March-based day.
`default_nettype none

module epoch_seconds_to_utc_calendar_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [63:0] epoch_seconds,
	output logic                    done,
	output logic                    ok,
	output logic signed [31:0]      years_since_1900,
	output logic [3:0]              month,
	output logic [4:0]              day_of_month,
	output logic [4:0]              hour,
	output logic [5:0]              minute,
	output logic [5:0]              second,
	output logic [2:0]              weekday,
	output logic [8:0]              day_of_year
);

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [2:0] weekday;
	} tod_t;

	typedef struct packed {
		logic [71:0] x;
		logic [17:0] rem;
		logic [47:0] q;
	} a_t;

	typedef struct packed {
		logic [47:0] z;
		logic [17:0] era_rem;
		logic [47:0] era_q;
		logic [17:0] w_rem;
		logic [23:0] t_x;
		logic [17:0] t_rem;
		logic [23:0] hq;
		logic [15:0] mq;
	} b_t;

	typedef struct packed {
		logic [23:0] x;
		logic [17:0] r1;
		logic [23:0] q1;
		logic [17:0] r2;
		logic [23:0] q2;
		logic [17:0] doe;
		logic [30:0] era;
		tod_t        tod;
	} c_t;

	typedef struct packed {
		logic [17:0] t;
		logic [17:0] doe;
		logic [30:0] era;
		tod_t        tod;
	} d_t;

	typedef struct packed {
		logic [23:0] x;
		logic [17:0] r;
		logic [23:0] q;
		logic [17:0] doe;
		logic [30:0] era;
		tod_t        tod;
	} f_t;

	typedef struct packed {
		logic [8:0]  doy;
		logic [8:0]  yoe;
		logic [30:0] era;
		tod_t        tod;
	} g_t;

	typedef struct packed {
		logic [3:0]  mp;
		logic [4:0]  mday;
		logic [8:0]  doy;
		logic [8:0]  yoe;
		logic [47:0] y0;
		tod_t        tod;
	} h_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] yrs;
		logic [3:0]  month;
		logic [4:0]  mday;
		logic [8:0]  doy;
		tod_t        tod;
	} o_t;

	logic                                 busy_q;
	logic                                 accept;
	logic [e2cal_pkg::PIPE_DEPTH-1:0]     vld_s;
	logic [65:0]                          x_sum;

	a_t a_s [0:e2cal_pkg::DAY_STAGES];
	b_t b_s [0:e2cal_pkg::ERA_STAGES-1];
	c_t c_s [0:e2cal_pkg::SUB_STAGES-1];
	d_t d_s1;
	f_t f_s [0:e2cal_pkg::SUB_STAGES-1];
	g_t g_s1;
	h_t h_s1;
	o_t o_s1;

	b_t b_init;
	c_t c_init;
	f_t f_init;

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			vld_s  <= '0;
		end else begin
			busy_q <= 1'b0;
			vld_s  <= {vld_s[e2cal_pkg::PIPE_DEPTH-2:0], accept};
		end
	end

	// seconds to days
	assign x_sum = {{2{epoch_seconds[63]}}, epoch_seconds} + e2cal_pkg::SEC_BIAS;

	always_ff @(posedge clk) begin
		a_s[0].x   <= {6'd0, x_sum};
		a_s[0].rem <= '0;
		a_s[0].q   <= '0;
	end

	for (genvar k = 1; k <= e2cal_pkg::DAY_STAGES; k++) begin : g_day
		logic [25:0] st;
		assign st = e2cal_pkg::div_step(a_s[k-1].rem, a_s[k-1].x[71:64],
			e2cal_pkg::SECS_PER_DAY);
		always_ff @(posedge clk) begin
			a_s[k].x   <= {a_s[k-1].x[63:0], 8'd0};
			a_s[k].rem <= st[25:8];
			a_s[k].q   <= {a_s[k-1].q[39:0], st[7:0]};
		end
	end

	// days to era and day of era; weekday; time of day
	always_comb begin
		b_init         = '0;
		b_init.z       = a_s[e2cal_pkg::DAY_STAGES].q;
		b_init.t_x     = {7'd0, a_s[e2cal_pkg::DAY_STAGES].rem[16:0]};
	end

	for (genvar j = 0; j < e2cal_pkg::ERA_STAGES; j++) begin : g_era
		b_t          bi;
		logic [25:0] se;
		logic [25:0] sw;
		logic [25:0] st;
		logic [17:0] tdv;
		if (j == 0) begin : g_first
			assign bi = b_init;
		end else begin : g_next
			assign bi = b_s[j-1];
		end
		if (j < 3) begin : g_hdv
			assign tdv = e2cal_pkg::SECS_PER_HOUR;
		end else begin : g_mdv
			assign tdv = e2cal_pkg::SECS_PER_MIN;
		end
		assign se = e2cal_pkg::div_step(bi.era_rem, bi.z[47:40], e2cal_pkg::DAYS_PER_ERA);
		assign sw = e2cal_pkg::div_step(bi.w_rem, bi.z[47:40], e2cal_pkg::DAYS_PER_WEEK);
		assign st = e2cal_pkg::div_step(bi.t_rem, bi.t_x[23:16], tdv);
		always_ff @(posedge clk) begin
			b_s[j].z       <= {bi.z[39:0], 8'd0};
			b_s[j].era_rem <= se[25:8];
			b_s[j].era_q   <= {bi.era_q[39:0], se[7:0]};
			b_s[j].w_rem   <= sw[25:8];
			if (j == 2) begin
				b_s[j].t_x   <= {st[23:8], 8'd0};
				b_s[j].t_rem <= '0;
			end else if (j == 5) begin
				b_s[j].t_x   <= bi.t_x;
				b_s[j].t_rem <= bi.t_rem;
			end else begin
				b_s[j].t_x   <= {bi.t_x[15:0], 8'd0};
				b_s[j].t_rem <= st[25:8];
			end
			if (j < 3) begin
				b_s[j].hq <= {bi.hq[15:0], st[7:0]};
			end else begin
				b_s[j].hq <= bi.hq;
			end
			if (j == 3 || j == 4) begin
				b_s[j].mq <= {bi.mq[7:0], st[7:0]};
			end else begin
				b_s[j].mq <= bi.mq;
			end
		end
	end

	// day of era to year of era
	always_comb begin
		logic [3:0] wsum;
		b_t         bl;
		bl             = b_s[e2cal_pkg::ERA_STAGES-1];
		wsum           = {1'b0, bl.w_rem[2:0]} + {1'b0, e2cal_pkg::WD_ADJ};
		c_init         = '0;
		c_init.x       = {6'd0, bl.era_rem};
		c_init.doe     = bl.era_rem;
		c_init.era     = bl.era_q[30:0];
		c_init.tod.hour    = bl.hq[4:0];
		c_init.tod.minute  = bl.mq[5:0];
		c_init.tod.second  = bl.t_rem[5:0];
		c_init.tod.weekday = (wsum >= 4'd7) ? 3'(wsum - 4'd7) : wsum[2:0];
	end

	for (genvar j = 0; j < e2cal_pkg::SUB_STAGES; j++) begin : g_sub
		c_t          ci;
		logic [25:0] s1;
		logic [25:0] s2;
		if (j == 0) begin : g_first
			assign ci = c_init;
		end else begin : g_next
			assign ci = c_s[j-1];
		end
		assign s1 = e2cal_pkg::div_step(ci.r1, ci.x[23:16], e2cal_pkg::DAYS_PER_4Y);
		assign s2 = e2cal_pkg::div_step(ci.r2, ci.x[23:16], e2cal_pkg::DAYS_PER_100Y);
		always_ff @(posedge clk) begin
			c_s[j].x   <= {ci.x[15:0], 8'd0};
			c_s[j].r1  <= s1[25:8];
			c_s[j].q1  <= {ci.q1[15:0], s1[7:0]};
			c_s[j].r2  <= s2[25:8];
			c_s[j].q2  <= {ci.q2[15:0], s2[7:0]};
			c_s[j].doe <= ci.doe;
			c_s[j].era <= ci.era;
			c_s[j].tod <= ci.tod;
		end
	end

	always_ff @(posedge clk) begin
		c_t cl;
		cl = c_s[e2cal_pkg::SUB_STAGES-1];
		d_s1.t   <= cl.doe - cl.q1[17:0] + cl.q2[17:0]
			- {17'd0, (cl.doe == e2cal_pkg::LAST_ERA_DAY)};
		d_s1.doe <= cl.doe;
		d_s1.era <= cl.era;
		d_s1.tod <= cl.tod;
	end

	always_comb begin
		f_init     = '0;
		f_init.x   = {6'd0, d_s1.t};
		f_init.doe = d_s1.doe;
		f_init.era = d_s1.era;
		f_init.tod = d_s1.tod;
	end

	for (genvar j = 0; j < e2cal_pkg::SUB_STAGES; j++) begin : g_yoe
		f_t          fi;
		logic [25:0] sy;
		if (j == 0) begin : g_first
			assign fi = f_init;
		end else begin : g_next
			assign fi = f_s[j-1];
		end
		assign sy = e2cal_pkg::div_step(fi.r, fi.x[23:16], e2cal_pkg::DAYS_PER_YEAR);
		always_ff @(posedge clk) begin
			f_s[j].x   <= {fi.x[15:0], 8'd0};
			f_s[j].r   <= sy[25:8];
			f_s[j].q   <= {fi.q[15:0], sy[7:0]};
			f_s[j].doe <= fi.doe;
			f_s[j].era <= fi.era;
			f_s[j].tod <= fi.tod;
		end
	end

	// day within the March-based year
	always_ff @(posedge clk) begin
		f_t          fl;
		logic [8:0]  yoe;
		logic [17:0] c100;
		logic [17:0] dd;
		fl   = f_s[e2cal_pkg::SUB_STAGES-1];
		yoe  = fl.q[8:0];
		c100 = {16'd0, 2'(yoe >= 9'd100) + 2'(yoe >= 9'd200) + 2'(yoe >= 9'd300)};
		dd   = fl.doe + c100 - {9'd0, yoe} * e2cal_pkg::DAYS_PER_YEAR - {11'd0, yoe[8:2]};
		g_s1.doy <= dd[8:0];
		g_s1.yoe <= yoe;
		g_s1.era <= fl.era;
		g_s1.tod <= fl.tod;
	end

	// month, day and year before the January correction
	always_ff @(posedge clk) begin
		logic [3:0]  mp;
		logic [8:0]  md;
		logic [47:0] era_v;
		mp = '0;
		for (int i = 1; i < 12; i++) begin
			if (e2cal_pkg::mar_start(4'(i)) <= g_s1.doy) begin
				mp = 4'(i);
			end
		end
		md    = g_s1.doy - e2cal_pkg::mar_start(mp) + 9'd1;
		era_v = {17'd0, g_s1.era} - e2cal_pkg::ERA_BIAS[47:0];
		h_s1.mp   <= mp;
		h_s1.mday <= md[4:0];
		h_s1.doy  <= g_s1.doy;
		h_s1.yoe  <= g_s1.yoe;
		h_s1.y0   <= (era_v << 8) + (era_v << 7) + (era_v << 4) + {39'd0, g_s1.yoe};
		h_s1.tod  <= g_s1.tod;
	end

	// January and February belong to the next year; range check and leap year
	always_ff @(posedge clk) begin
		logic        jf;
		logic [47:0] yrs;
		logic        fits;
		logic [9:0]  v;
		logic        leap;
		jf   = (h_s1.mp >= 4'd10);
		yrs  = h_s1.y0 + {47'd0, jf} - e2cal_pkg::BASE_YEAR;
		fits = (yrs[47:31] == 17'h00000) || (yrs[47:31] == 17'h1ffff);
		v    = {1'b0, h_s1.yoe} + {9'd0, jf};
		if (v == 10'd400) begin
			v = '0;
		end
		leap = (v[1:0] == 2'd0) && (v != 10'd100) && (v != 10'd200) && (v != 10'd300);
		o_s1.ok  <= fits;
		o_s1.tod <= h_s1.tod;
		if (fits) begin
			o_s1.yrs   <= yrs[31:0];
			o_s1.month <= jf ? (h_s1.mp - 4'd10) : (h_s1.mp + 4'd2);
			o_s1.mday  <= h_s1.mday;
			o_s1.doy   <= jf ? (h_s1.doy - 9'd306) : (h_s1.doy + 9'd59 + {8'd0, leap});
		end else begin
			o_s1.yrs   <= '0;
			o_s1.month <= '0;
			o_s1.mday  <= '0;
			o_s1.doy   <= '0;
		end
	end

	assign done             = vld_s[e2cal_pkg::PIPE_DEPTH-1];
	assign ok               = o_s1.ok;
	assign years_since_1900 = o_s1.yrs;
	assign month            = o_s1.month;
	assign day_of_month     = o_s1.mday;
	assign day_of_year      = o_s1.doy;
	assign hour             = o_s1.tod.hour;
	assign minute           = o_s1.tod.minute;
	assign second           = o_s1.tod.second;
	assign weekday          = o_s1.tod.weekday;

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (hour <= 5'd23) && (minute <= 6'd59) && (second <= 6'd59) && (weekday <= 3'd6))
		else $error("time of day out of range");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !ok |-> (years_since_1900 == 32'sd0) && (month == 4'd0)
			&& (day_of_month == 5'd0) && (day_of_year == 9'd0))
		else $error("date fields not cleared on range error");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && ok |-> (month <= 4'd11) && (day_of_month != 5'd0) && (day_of_year <= 9'd365))
		else $error("date fields out of range");

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> !busy)
		else $error("busy raised after reset");

endmodule

`default_nettype wire

FILE: sim/epoch_seconds_to_utc_calendar_top_tb.sv
// Testbench for epoch_seconds_to_utc_calendar_top: directed and random epoch words,
// predicted calendar breakdown checked field by field. Needs only the RTL and e2cal_pkg.
`timescale 1ns / 1ps

module epoch_seconds_to_utc_calendar_top_tb;

	typedef struct packed {
		logic               ok;
		logic signed [31:0] years_since_1900;
		logic [3:0]         month;
		logic [4:0]         day_of_month;
		logic [4:0]         hour;
		logic [5:0]         minute;
		logic [5:0]         second;
		logic [2:0]         weekday;
		logic [8:0]         day_of_year;
	} calendar_t;

	localparam int      YEAR_STEPS  = 8;
	localparam longint  LEAP_OFFSET = 64'sd4000000000;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [63:0] epoch_seconds;
	logic               done;
	logic               ok;
	logic signed [31:0] years_since_1900;
	logic [3:0]         month;
	logic [4:0]         day_of_month;
	logic [4:0]         hour;
	logic [5:0]         minute;
	logic [5:0]         second;
	logic [2:0]         weekday;
	logic [8:0]         day_of_year;

	longint    pending_epochs[$];
	calendar_t expected_dates[$];
	int        taken;
	int        gap_left;
	int        idle_until;
	bit        failed;

	epoch_seconds_to_utc_calendar_top dut (.*);

	function automatic bit is_leap(longint y);
		return (y % 4 == 0 && (y % 100 != 0 || y % 400 == 0));
	endfunction

	function automatic longint leaps_to(longint y);
		longint s;
		s = y + LEAP_OFFSET;
		return s / 4 - s / 100 + s / 400;
	endfunction

	function automatic calendar_t calendar_of(longint e);
		calendar_t c;
		longint    days, rem, wd, y, ny, yrs, doy, mon;
		bit        valid, lp;
		int        cum[2][12] = '{'{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334},
			'{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335}};
		days  = e / 86400;
		rem   = e % 86400;
		valid = 1;
		lp    = 0;
		yrs   = 0;
		doy   = 0;
		mon   = 0;
		if (rem < 0) begin
			rem  += 86400;
			days -= 1;
		end
		wd = (4 + days) % 7;
		if (wd < 0)
			wd += 7;
		c.hour    = 5'(rem / 3600);
		c.minute  = 6'((rem % 3600) / 60);
		c.second  = 6'(rem % 60);
		c.weekday = 3'(wd);
		y = 1970;
		if (y + days / 365 <= -LEAP_OFFSET + 10)
			valid = 0;
		if (valid) begin
			for (int i = 0; i < YEAR_STEPS; i++) begin
				if (days < 0 || days >= 365 + is_leap(y)) begin
					ny = y + days / 365 - (days < 0 ? 1 : 0);
					days -= 365 * (ny - y) + leaps_to(ny - 1) - leaps_to(y - 1);
					y = ny;
				end
			end
			lp = is_leap(y);
			if (days < 0 || days >= 365 + lp)
				valid = 0;
		end
		if (valid) begin
			yrs = y - 1900;
			if (yrs > 64'sd2147483647 || yrs < -64'sd2147483648)
				valid = 0;
		end
		if (valid) begin
			doy = days;
			for (int i = 1; i < 12; i++)
				if (cum[lp][i] <= doy)
					mon = i;
			c.day_of_month = 5'(doy - cum[lp][mon] + 1);
		end else begin
			yrs = 0;
			doy = 0;
			mon = 0;
			c.day_of_month = '0;
		end
		c.ok               = valid;
		c.years_since_1900 = 32'(yrs);
		c.month            = 4'(mon);
		c.day_of_year      = 9'(doy);
		return c;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// driver: one word per handshake, random idle bursts early on
	always @(negedge clk) begin
		if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			start    <= 0;
		end else if (taken < pending_epochs.size()) begin
			if (taken < idle_until && $urandom_range(0, 7) == 0) begin
				gap_left <= $urandom_range(0, 9);
				start    <= 0;
			end else begin
				start         <= 1;
				epoch_seconds <= pending_epochs[taken];
			end
		end else
			start <= 0;
	end

	// monitor
	always @(posedge clk) begin
		calendar_t want;
		if (arst_n && start && !busy) begin
			expected_dates.push_back(calendar_of(epoch_seconds));
			taken <= taken + 1;
		end
		if (arst_n && done) begin
			if (expected_dates.size() == 0) begin
				$error("unexpected word");
				failed = 1;
			end else begin
				want = expected_dates.pop_front();
				if (ok !== want.ok) begin
					$error("ok: expected %0d, got %0d", want.ok, ok); failed = 1;
				end
				if (years_since_1900 !== want.years_since_1900) begin
					$error("years_since_1900: expected %0d, got %0d",
						want.years_since_1900, years_since_1900); failed = 1;
				end
				if (month !== want.month) begin
					$error("month: expected %0d, got %0d", want.month, month); failed = 1;
				end
				if (day_of_month !== want.day_of_month) begin
					$error("day_of_month: expected %0d, got %0d",
						want.day_of_month, day_of_month); failed = 1;
				end
				if (hour !== want.hour) begin
					$error("hour: expected %0d, got %0d", want.hour, hour); failed = 1;
				end
				if (minute !== want.minute) begin
					$error("minute: expected %0d, got %0d", want.minute, minute); failed = 1;
				end
				if (second !== want.second) begin
					$error("second: expected %0d, got %0d", want.second, second); failed = 1;
				end
				if (weekday !== want.weekday) begin
					$error("weekday: expected %0d, got %0d", want.weekday, weekday); failed = 1;
				end
				if (day_of_year !== want.day_of_year) begin
					$error("day_of_year: expected %0d, got %0d",
						want.day_of_year, day_of_year); failed = 1;
				end
			end
		end
	end

	initial begin
		longint v;
		start         = 0;
		epoch_seconds = '0;
		taken         = 0;
		gap_left      = 0;
		failed        = 0;
		arst_n        = 0;
		// directed: extremes, day and leap edges, 32-bit year limits, guard region
		pending_epochs = '{0, -1, 1, 86399, 86400, -86400, -86401,
			64'sh7fffffffffffffff, 64'sh8000000000000000,
			951782400, 951868799, 951868800, -64'sd2203891200, -64'sd2208988800,
			-64'sd62135596800, -64'sd62167219200, -64'sd62167219201, 64'sd253402300799,
			64'sd67768036191676799, 64'sd67768036191676800,
			-64'sd67768040609740800, -64'sd67768040609740801,
			-64'sd126230400000000000, -64'sd126000000000000000, 1700000000};
		for (int i = 0; i < 450; i++) begin
			case ($urandom_range(0, 4))
				0: v = {$urandom, $urandom};
				1: v = longint'($signed({$urandom, $urandom})) >>> $urandom_range(0, 62);
				2: v = longint'($urandom_range(0, 8000)) * 86400 - 345600000
					+ $urandom_range(0, 2) - 1;
				3: v = longint'($signed({$urandom, $urandom})) % 64'sd67768040609740802;
				default: v = longint'($signed({$urandom, $urandom})) % 64'sd160000000000000000;
			endcase
			pending_epochs.push_back(v);
		end
		idle_until = pending_epochs.size() * 4 / 5;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1;
		wait (taken == pending_epochs.size());
		wait (expected_dates.size() == 0);
		repeat (30) @(posedge clk);
		if (!failed && expected_dates.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2ms;
		$display("Verification failed");
		$finish;
	end

endmodule
